FILE: design/osf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osf_pkg
// Shared types and constants for the overlapping substring finder.
// ---------------------------------------------------------------------------
package osf_pkg;

    localparam int MAX_PATTERN_CHARS = 8;
    localparam int LINE_BITS         = 16;
    localparam int COLUMN_BITS       = 16;

    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 4;
    localparam int POS_W   = 3;
    localparam int INDEX_W = 2;
    localparam int PAT_W   = 64;
    localparam int OUT_W   = 16;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;

    // Input command codes
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    typedef struct packed {
        logic              command;
        logic [CHAR_W-1:0] character;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] line_number;
        logic [OUT_W-1:0] start_column;
        logic [LEN_W-1:0] match_length;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: design/osf_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// osf_cell
// One history cell: compare the incoming character with its pattern byte,
// hold it and pass it to the next cell on a shift, and zero it on a clear.
// ---------------------------------------------------------------------------
module osf_cell
    import osf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] char_in,
    input  logic [POS_W-1:0]  position,
    input  logic [PAT_W-1:0]  pattern,
    input  logic [LEN_W-1:0]  length,
    output logic [CHAR_W-1:0] char_out,
    output logic              ok
);

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic              active;
    logic [POS_W-1:0]  want_idx;
    logic [CHAR_W-1:0] want;

    // Cell at distance d checks pattern byte length-1-d
    assign active   = {1'b0, position} < length;
    assign want_idx = length[POS_W-1:0] - 3'd1 - position;
    assign want     = pattern[want_idx*CHAR_W +: CHAR_W];
    assign ok       = !active || (want == char_in);

    always_comb
    begin
        char_next = char_reg;
        if (ctrl.clear)
        begin
            char_next = '0;
        end
        else if (ctrl.shift)
        begin
            char_next = char_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
        end
        else
        begin
            char_reg <= char_next;
        end
    end

    assign char_out = char_reg;

endmodule

FILE: design/overlapping_substring_finder_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// overlapping_substring_finder_top
// Stream text items through a row of compare cells and report every
// overlapping match of the configured pattern with line, column and length.
// ---------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_ready   | in_item  (command, character)
//  out     | out_valid / out_ready | out_item (line, start column, length)
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data (always ready)
//
//  One item per cycle while not stalled: the compare over all cells is a
//  single parallel AND, and a result reaches the output register in the
//  cycle after its item. The only stall is a held result: in_ready drops
//  while out_valid waits on out_ready.
//  Reset clears the history cells, both counters, the pattern registers and
//  the output valid; no clearing pass is needed.
//
module overlapping_substring_finder_top
    import osf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [INDEX_W-1:0] cfg_index,
    input  logic [PAT_W-1:0]   cfg_data
);

    // Configuration registers
    logic [PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0] length_reg;

    // Position counters
    logic [COLUMN_BITS-1:0] column_reg;
    logic [COLUMN_BITS-1:0] column_next;
    logic [LINE_BITS-1:0]   line_reg;
    logic [LINE_BITS-1:0]   line_next;

    // Output stage
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic                           accept;
    cell_ctrl_t                     ctrl;
    logic [CHAR_W-1:0]              chain [MAX_PATTERN_CHARS+1];
    logic [MAX_PATTERN_CHARS-1:0]   cell_ok;
    logic                           len_valid;
    logic [COLUMN_BITS-1:0]         len_minus_one;
    logic                           hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PATTERN_BYTES:  pattern_reg <= cfg_data;
                REG_PATTERN_LENGTH: length_reg  <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Take a new item unless a result is held
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign ctrl.shift = accept && (in_item.command == CMD_CHAR);
    assign ctrl.clear = accept && (in_item.command == CMD_EOL);

    // Cell 0 sees the incoming character; each later cell sees the one before
    assign chain[0] = in_item.character;

    for (genvar i = 0; i < MAX_PATTERN_CHARS; i++)
    begin : g_cell
        osf_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .char_in  (chain[i]),
            .position (POS_W'(i)),
            .pattern  (pattern_reg),
            .length   (length_reg),
            .char_out (chain[i+1]),
            .ok       (cell_ok[i])
        );
    end

    // Match only for a usable length and once the line holds enough characters
    assign len_valid     = (length_reg != '0) &&
                           (length_reg <= LEN_W'(MAX_PATTERN_CHARS));
    assign len_minus_one = COLUMN_BITS'(length_reg) - COLUMN_BITS'(1);
    assign hit           = len_valid && (column_reg >= len_minus_one) && (&cell_ok);

    // Advance counters, saturating at their maximum
    always_comb
    begin
        column_next = column_reg;
        line_next   = line_reg;
        if (ctrl.clear)
        begin
            column_next = '0;
            if (line_reg != '1)
            begin
                line_next = line_reg + LINE_BITS'(1);
            end
        end
        else if (ctrl.shift)
        begin
            if (column_reg != '1)
            begin
                column_next = column_reg + COLUMN_BITS'(1);
            end
        end
    end

    // Load a result on a hit, drop it once taken, hold it while stalled
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (in_ready)
        begin
            out_valid_next = ctrl.shift && hit;
        end
        if (ctrl.shift && hit)
        begin
            out_item_next.line_number  = OUT_W'(line_reg);
            out_item_next.start_column = OUT_W'(column_reg - len_minus_one);
            out_item_next.match_length = length_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            column_reg    <= column_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
